// ===== design/gtpg_pkg.sv =====
package gtpg_pkg;

   // Field widths.
   localparam int CHAR_W  = 8;
   localparam int COORD_W = 16;
   localparam int COLOR_W = 16;

   // Character cell geometry.
   localparam int GLYPH_COUNT = 41;
   localparam int FONT_COLS   = 5;
   localparam int CELL_COLS   = 6;
   localparam int CELL_ROWS   = 8;
   localparam int GLYPH_W     = 6;
   localparam int COL_W       = 3;
   localparam int ROW_W       = 3;

   localparam logic [GLYPH_W-1:0] NO_GLYPH     = 6'h3F;
   localparam logic [GLYPH_W-1:0] GLYPH_DIGIT0 = 6'd26;
   localparam logic [GLYPH_W-1:0] GLYPH_PERIOD = 6'd36;
   localparam logic [GLYPH_W-1:0] GLYPH_MINUS  = 6'd37;
   localparam logic [GLYPH_W-1:0] GLYPH_COLON  = 6'd38;
   localparam logic [GLYPH_W-1:0] GLYPH_LPAREN = 6'd39;
   localparam logic [GLYPH_W-1:0] GLYPH_RPAREN = 6'd40;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   localparam logic [COL_W-1:0] LAST_COL    = 3'd5;
   localparam logic [ROW_W-1:0] LAST_ROW    = 3'd7;
   localparam logic [COL_W-1:0] SPACING_COL = 3'd5;

   localparam logic [COORD_W-1:0] CURSOR_STEP = 16'd6;
   localparam logic [COORD_W-1:0] WIN_DX      = 16'd5;
   localparam logic [COORD_W-1:0] WIN_DY      = 16'd7;

   // Result kinds.
   localparam logic KIND_WINDOW = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] CSR_BG_INDEX = 1'b0;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // One glyph job handed from front to back.
   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COLOR_W-1:0] fg;
   } job_type;

   // Maps a character code to its font entry, or NO_GLYPH.
   function automatic logic [GLYPH_W-1:0] glyph_index(input logic [CHAR_W-1:0] c);
      logic [GLYPH_W-1:0] idx;
      idx = NO_GLYPH;
      if (c >= 8'h41 && c <= 8'h5A) begin
         idx = GLYPH_W'(c - 8'h41);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         idx = GLYPH_DIGIT0 + GLYPH_W'(c - 8'h30);
      end else if (c == 8'h2E) begin
         idx = GLYPH_PERIOD;
      end else if (c == 8'h2D) begin
         idx = GLYPH_MINUS;
      end else if (c == 8'h3A) begin
         idx = GLYPH_COLON;
      end else if (c == 8'h28) begin
         idx = GLYPH_LPAREN;
      end else if (c == 8'h29) begin
         idx = GLYPH_RPAREN;
      end
      return idx;
   endfunction

   // Font columns of one glyph, leftmost column in the top byte.
   function automatic logic [8*FONT_COLS-1:0] glyph_bitmap(input logic [GLYPH_W-1:0] g);
      logic [8*FONT_COLS-1:0] bm;
      unique case (g)
         6'd0:  bm = 40'h7E_11_11_11_7E;
         6'd1:  bm = 40'h7F_49_49_49_36;
         6'd2:  bm = 40'h3E_41_41_41_22;
         6'd3:  bm = 40'h7F_41_41_22_1C;
         6'd4:  bm = 40'h7F_49_49_49_41;
         6'd5:  bm = 40'h7F_09_09_09_01;
         6'd6:  bm = 40'h3E_41_49_49_7A;
         6'd7:  bm = 40'h7F_08_08_08_7F;
         6'd8:  bm = 40'h00_41_7F_41_00;
         6'd9:  bm = 40'h20_40_41_3F_01;
         6'd10: bm = 40'h7F_08_14_22_41;
         6'd11: bm = 40'h7F_40_40_40_40;
         6'd12: bm = 40'h7F_02_0C_02_7F;
         6'd13: bm = 40'h7F_04_08_10_7F;
         6'd14: bm = 40'h3E_41_41_41_3E;
         6'd15: bm = 40'h7F_09_09_09_06;
         6'd16: bm = 40'h3E_41_51_21_5E;
         6'd17: bm = 40'h7F_09_19_29_46;
         6'd18: bm = 40'h46_49_49_49_31;
         6'd19: bm = 40'h01_01_7F_01_01;
         6'd20: bm = 40'h3F_40_40_40_3F;
         6'd21: bm = 40'h1F_20_40_20_1F;
         6'd22: bm = 40'h3F_40_38_40_3F;
         6'd23: bm = 40'h63_14_08_14_63;
         6'd24: bm = 40'h07_08_70_08_07;
         6'd25: bm = 40'h61_51_49_45_43;
         6'd26: bm = 40'h3E_51_49_45_3E;
         6'd27: bm = 40'h00_42_7F_40_00;
         6'd28: bm = 40'h42_61_51_49_46;
         6'd29: bm = 40'h21_41_45_4B_31;
         6'd30: bm = 40'h18_14_12_7F_10;
         6'd31: bm = 40'h27_45_45_45_39;
         6'd32: bm = 40'h3C_4A_49_49_30;
         6'd33: bm = 40'h01_71_09_05_03;
         6'd34: bm = 40'h36_49_49_49_36;
         6'd35: bm = 40'h06_49_49_29_1E;
         6'd36: bm = 40'h00_00_60_60_00;
         6'd37: bm = 40'h08_08_08_08_08;
         6'd38: bm = 40'h00_00_36_36_00;
         6'd39: bm = 40'h00_1C_22_41_00;
         6'd40: bm = 40'h00_41_22_1C_00;
         default: bm = '0;
      endcase
      return bm;
   endfunction

   // One font column byte; the spacing column reads as empty.
   function automatic logic [7:0] font_column(input logic [GLYPH_W-1:0] g,
                                              input logic [COL_W-1:0]   col);
      logic [8*FONT_COLS-1:0] bm;
      logic [7:0]             byte_out;
      bm = glyph_bitmap(g);
      unique case (col)
         3'd0:    byte_out = bm[39:32];
         3'd1:    byte_out = bm[31:24];
         3'd2:    byte_out = bm[23:16];
         3'd3:    byte_out = bm[15:8];
         3'd4:    byte_out = bm[7:0];
         default: byte_out = 8'h00;
      endcase
      return byte_out;
   endfunction

endpackage

// ===== design/gtpg_front.sv =====
module gtpg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gtpg_pkg::CHAR_W-1:0]   req_char_code,
   input  logic                          req_restart,
   input  logic [gtpg_pkg::COORD_W-1:0]  req_start_x,
   input  logic [gtpg_pkg::COORD_W-1:0]  req_start_y,
   input  logic [gtpg_pkg::COLOR_W-1:0]  req_fg_color,
   output logic                          job_valid,
   input  logic                          job_ready,
   output gtpg_pkg::job_type             job
);

   logic [gtpg_pkg::COORD_W-1:0] cursor_col_ff, cursor_col_in;
   logic [gtpg_pkg::COORD_W-1:0] cursor_row_ff, cursor_row_in;
   logic [gtpg_pkg::COORD_W-1:0] base_col, base_row;
   logic [gtpg_pkg::GLYPH_W-1:0] glyph;
   logic                         is_space, is_glyph, accept;

   // Classify the word: glyph, space or ignored.
   always_comb begin
      glyph    = gtpg_pkg::glyph_index(req_char_code);
      is_space = (req_char_code == gtpg_pkg::CHAR_SPACE);
      is_glyph = (glyph != gtpg_pkg::NO_GLYPH);
      base_col = req_restart ? req_start_x : cursor_col_ff;
      base_row = req_restart ? req_start_y : cursor_row_ff;
   end

   // Words are taken whenever the queue has room.
   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;

   // Glyphs go to the queue with the cursor they are drawn at.
   assign job_valid = req_valid && is_glyph;
   assign job.glyph = glyph;
   assign job.x0    = base_col;
   assign job.y0    = base_row;
   assign job.fg    = req_fg_color;

   // Cursor update: spaces and glyphs step right by one cell.
   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      if (accept) begin
         cursor_row_in = base_row;
         cursor_col_in = (is_space || is_glyph) ? base_col + gtpg_pkg::CURSOR_STEP
                                                : base_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

endmodule

// ===== design/gtpg_queue.sv =====
module gtpg_queue #(
   parameter int DEPTH = gtpg_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  gtpg_pkg::job_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output gtpg_pkg::job_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   gtpg_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   // The fill count never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   // An empty queue has both pointers together.
   assert property (@(posedge clock) disable iff (reset)
                    (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with empty count");
`endif

endmodule

// ===== design/gtpg_back.sv =====
module gtpg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  gtpg_pkg::job_type             job,
   input  logic [gtpg_pkg::COLOR_W-1:0]  backdrop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [gtpg_pkg::COORD_W-1:0]  rsp_win_x0,
   output logic [gtpg_pkg::COORD_W-1:0]  rsp_win_y0,
   output logic [gtpg_pkg::COORD_W-1:0]  rsp_win_x1,
   output logic [gtpg_pkg::COORD_W-1:0]  rsp_win_y1,
   output logic [gtpg_pkg::COLOR_W-1:0]  rsp_pixel_color,
   output logic                          rsp_last
);

   gtpg_pkg::job_type              job_ff;
   logic                           busy_ff, win_pending_ff;
   logic [gtpg_pkg::COL_W-1:0]     col_ff;
   logic [gtpg_pkg::ROW_W-1:0]     row_ff;
   logic                           rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [gtpg_pkg::COORD_W-1:0]   rsp_x0_ff, rsp_y0_ff, rsp_x1_ff, rsp_y1_ff;
   logic [gtpg_pkg::COLOR_W-1:0]   rsp_pixel_ff;
   logic [7:0]                     col_bits;
   logic [gtpg_pkg::COLOR_W-1:0]   pixel;
   logic                           out_free, emit, final_px, load;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = busy_ff && out_free;
   assign final_px = !win_pending_ff && (row_ff == gtpg_pkg::LAST_ROW)
                     && (col_ff == gtpg_pkg::LAST_COL);
   // Take the next job as soon as the current one hands out its last pixel.
   assign load      = job_valid && (!busy_ff || (emit && final_px));
   assign job_ready = load;

   // Pixel colour from the font column bit at the current row.
   always_comb begin
      col_bits = gtpg_pkg::font_column(job_ff.glyph, col_ff);
      pixel    = ((col_ff != gtpg_pkg::SPACING_COL) && col_bits[row_ff]) ? job_ff.fg
                                                                          : backdrop;
   end

   // Sequencer over the window word and the 6 by 8 pixel cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         win_pending_ff <= 1'b0;
         col_ff         <= '0;
         row_ff         <= '0;
      end else if (load) begin
         busy_ff        <= 1'b1;
         win_pending_ff <= 1'b1;
         col_ff         <= '0;
         row_ff         <= '0;
      end else if (emit) begin
         if (win_pending_ff) begin
            win_pending_ff <= 1'b0;
         end else if (final_px) begin
            busy_ff <= 1'b0;
         end else if (col_ff == gtpg_pkg::LAST_COL) begin
            col_ff <= '0;
            row_ff <= row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (win_pending_ff) begin
            rsp_kind_ff  <= gtpg_pkg::KIND_WINDOW;
            rsp_x0_ff    <= job_ff.x0;
            rsp_y0_ff    <= job_ff.y0;
            rsp_x1_ff    <= job_ff.x0 + gtpg_pkg::WIN_DX;
            rsp_y1_ff    <= job_ff.y0 + gtpg_pkg::WIN_DY;
            rsp_pixel_ff <= '0;
            rsp_last_ff  <= 1'b0;
         end else begin
            rsp_kind_ff  <= gtpg_pkg::KIND_PIXEL;
            rsp_x0_ff    <= '0;
            rsp_y0_ff    <= '0;
            rsp_x1_ff    <= '0;
            rsp_y1_ff    <= '0;
            rsp_pixel_ff <= pixel;
            rsp_last_ff  <= final_px;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_win_x0      = rsp_x0_ff;
   assign rsp_win_y0      = rsp_y0_ff;
   assign rsp_win_x1      = rsp_x1_ff;
   assign rsp_win_y1      = rsp_y1_ff;
   assign rsp_pixel_color = rsp_pixel_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   // A new job is only taken when idle or on the final pixel of the last one.
   assert property (@(posedge clock) disable iff (reset)
                    load |-> (!busy_ff || final_px))
      else $error("job loaded in the middle of a glyph");

   // The last flag only ever marks a pixel word.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_last) |-> (rsp_kind == gtpg_pkg::KIND_PIXEL))
      else $error("last flag on a window word");

   // The window word of a job always comes out with the pixel counters at rest.
   assert property (@(posedge clock) disable iff (reset)
                    (busy_ff && win_pending_ff) |-> (col_ff == '0 && row_ff == '0))
      else $error("pixel counters moved before the window word");

   // After a window word is handed out, the next word of the glyph is its first pixel.
   assert property (@(posedge clock) disable iff (reset)
                    (emit && win_pending_ff) |=> (!win_pending_ff && busy_ff))
      else $error("window word not followed by pixels");
`endif

endmodule

// ===== design/glyph_text_pixel_generator.sv =====
// Character generator for a 5x8 column font on an RGB565 display stream.
// Each input word carries one character; A-Z, 0-9 and . - : ( ) are drawn
// at the text cursor as one window word (x0, y0, x0+5, y0+7) followed by
// 48 pixel words, row by row over a cell six columns wide and eight rows
// high, the sixth column being background spacing; the cursor then steps
// right by six. A space only steps the cursor, and any other code is
// dropped. Restart loads the cursor from start_x/start_y first. A glyph
// occupies the output for one window word and 48 pixel words, one word per
// cycle while the receiver is ready, and that output sequencer sets the
// sustained rate. A small job queue between the input classifier and the
// output sequencer lets the next characters be taken while a glyph is being
// drawn. The background colour register sits at byte address 0.
module glyph_text_pixel_generator #(
   parameter int QUEUE_DEPTH = gtpg_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // Register port.
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gtpg_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [gtpg_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [gtpg_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   // Character input.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [gtpg_pkg::CHAR_W-1:0]        req_char_code,
   input  logic                               req_restart,
   input  logic [gtpg_pkg::COORD_W-1:0]       req_start_x,
   input  logic [gtpg_pkg::COORD_W-1:0]       req_start_y,
   input  logic [gtpg_pkg::COLOR_W-1:0]       req_fg_color,
   // Window and pixel output.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_kind,
   output logic [gtpg_pkg::COORD_W-1:0]       rsp_win_x0,
   output logic [gtpg_pkg::COORD_W-1:0]       rsp_win_y0,
   output logic [gtpg_pkg::COORD_W-1:0]       rsp_win_x1,
   output logic [gtpg_pkg::COORD_W-1:0]       rsp_win_y1,
   output logic [gtpg_pkg::COLOR_W-1:0]       rsp_pixel_color,
   output logic                               rsp_last
);

   logic [gtpg_pkg::COLOR_W-1:0] backdrop_ff;
   logic                         bg_sel;
   logic                         front_valid, front_ready;
   gtpg_pkg::job_type            front_job;
   logic                         back_valid, back_ready;
   gtpg_pkg::job_type            back_job;

   // Register decode on the word index.
   assign bg_sel = (paddr[gtpg_pkg::CSR_ADDR_W-1:2] == gtpg_pkg::CSR_BG_INDEX);
   assign pready = 1'b1;
   assign prdata = bg_sel ? {{(gtpg_pkg::CSR_DATA_W - gtpg_pkg::COLOR_W){1'b0}}, backdrop_ff}
                          : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         backdrop_ff <= '0;
      end else if (psel && penable && pwrite && pready && bg_sel) begin
         backdrop_ff <= pwdata[gtpg_pkg::COLOR_W-1:0];
      end
   end

   // Input classifier and cursor.
   gtpg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_restart   (req_restart),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_fg_color  (req_fg_color),
      .job_valid     (front_valid),
      .job_ready     (front_ready),
      .job           (front_job)
   );

   // Glyph job queue.
   gtpg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   // Window and pixel sequencer.
   gtpg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (back_valid),
      .job_ready       (back_ready),
      .job             (back_job),
      .backdrop        (backdrop_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_win_x0      (rsp_win_x0),
      .rsp_win_y0      (rsp_win_y0),
      .rsp_win_x1      (rsp_win_x1),
      .rsp_win_y1      (rsp_win_y1),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int REPORT_LIMIT = 10;

   localparam logic [gtpg_pkg::CSR_ADDR_W-1:0] ADDR_BACKGROUND =
      gtpg_pkg::CSR_ADDR_W'(4 * gtpg_pkg::CSR_BG_INDEX);
   // Byte address of register index 1, which the block does not implement.
   localparam logic [gtpg_pkg::CSR_ADDR_W-1:0] ADDR_UNMAPPED = gtpg_pkg::CSR_ADDR_W'(4);

   // Character codes used by the font lookup and the directed words.
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_A       = 8'h41;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_Z       = 8'h5A;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_0       = 8'h30;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_9       = 8'h39;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_PERIOD  = 8'h2E;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_COLON   = 8'h3A;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_LPAREN  = 8'h28;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_RPAREN  = 8'h29;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_AT      = 8'h40;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_HIGH    = 8'h80;
   localparam logic [gtpg_pkg::CHAR_W-1:0] CH_TOP     = 8'hFF;

   // One word on the result channel.
   typedef struct packed {
      logic                         kind;
      logic [gtpg_pkg::COORD_W-1:0] x0;
      logic [gtpg_pkg::COORD_W-1:0] y0;
      logic [gtpg_pkg::COORD_W-1:0] x1;
      logic [gtpg_pkg::COORD_W-1:0] y1;
      logic [gtpg_pkg::COLOR_W-1:0] color;
      logic                         last;
   } gen_word_type;

   // Tracks the cursor and background colour, and holds the words still owed.
   class glyph_predictor;
      gen_word_type                 pending_words[$];
      logic [gtpg_pkg::COORD_W-1:0] cursor_col;
      logic [gtpg_pkg::COORD_W-1:0] cursor_row;
      logic [gtpg_pkg::COLOR_W-1:0] background;
      int                           mismatches;

      function new();
         cursor_col = '0;
         cursor_row = '0;
         background = '0;
         mismatches = 0;
      endfunction

      // Font entry of a character, or -1 where it has none.
      static function int glyph_of(logic [gtpg_pkg::CHAR_W-1:0] c);
         int g;
         g = -1;
         if (c >= CH_A && c <= CH_Z) begin
            g = int'(c - CH_A);
         end else if (c >= CH_0 && c <= CH_9) begin
            g = int'(gtpg_pkg::GLYPH_DIGIT0) + int'(c - CH_0);
         end else if (c == CH_PERIOD) begin
            g = int'(gtpg_pkg::GLYPH_PERIOD);
         end else if (c == CH_MINUS) begin
            g = int'(gtpg_pkg::GLYPH_MINUS);
         end else if (c == CH_COLON) begin
            g = int'(gtpg_pkg::GLYPH_COLON);
         end else if (c == CH_LPAREN) begin
            g = int'(gtpg_pkg::GLYPH_LPAREN);
         end else if (c == CH_RPAREN) begin
            g = int'(gtpg_pkg::GLYPH_RPAREN);
         end
         return g;
      endfunction

      // Five column bytes of a glyph, the leftmost column in the top byte.
      static function logic [39:0] font_columns(int g);
         logic [39:0] cols;
         case (g)
            0:  cols = 40'h7E_11_11_11_7E;
            1:  cols = 40'h7F_49_49_49_36;
            2:  cols = 40'h3E_41_41_41_22;
            3:  cols = 40'h7F_41_41_22_1C;
            4:  cols = 40'h7F_49_49_49_41;
            5:  cols = 40'h7F_09_09_09_01;
            6:  cols = 40'h3E_41_49_49_7A;
            7:  cols = 40'h7F_08_08_08_7F;
            8:  cols = 40'h00_41_7F_41_00;
            9:  cols = 40'h20_40_41_3F_01;
            10: cols = 40'h7F_08_14_22_41;
            11: cols = 40'h7F_40_40_40_40;
            12: cols = 40'h7F_02_0C_02_7F;
            13: cols = 40'h7F_04_08_10_7F;
            14: cols = 40'h3E_41_41_41_3E;
            15: cols = 40'h7F_09_09_09_06;
            16: cols = 40'h3E_41_51_21_5E;
            17: cols = 40'h7F_09_19_29_46;
            18: cols = 40'h46_49_49_49_31;
            19: cols = 40'h01_01_7F_01_01;
            20: cols = 40'h3F_40_40_40_3F;
            21: cols = 40'h1F_20_40_20_1F;
            22: cols = 40'h3F_40_38_40_3F;
            23: cols = 40'h63_14_08_14_63;
            24: cols = 40'h07_08_70_08_07;
            25: cols = 40'h61_51_49_45_43;
            26: cols = 40'h3E_51_49_45_3E;
            27: cols = 40'h00_42_7F_40_00;
            28: cols = 40'h42_61_51_49_46;
            29: cols = 40'h21_41_45_4B_31;
            30: cols = 40'h18_14_12_7F_10;
            31: cols = 40'h27_45_45_45_39;
            32: cols = 40'h3C_4A_49_49_30;
            33: cols = 40'h01_71_09_05_03;
            34: cols = 40'h36_49_49_49_36;
            35: cols = 40'h06_49_49_29_1E;
            36: cols = 40'h00_00_60_60_00;
            37: cols = 40'h08_08_08_08_08;
            38: cols = 40'h00_00_36_36_00;
            39: cols = 40'h00_1C_22_41_00;
            40: cols = 40'h00_41_22_1C_00;
            default: cols = '0;
         endcase
         return cols;
      endfunction

      function void set_background(logic [gtpg_pkg::COLOR_W-1:0] value);
         background = value;
      endfunction

      // Works out the words that one accepted character causes.
      function void take_char(logic [gtpg_pkg::CHAR_W-1:0] c, logic restart,
                              logic [gtpg_pkg::COORD_W-1:0] sx,
                              logic [gtpg_pkg::COORD_W-1:0] sy,
                              logic [gtpg_pkg::COLOR_W-1:0] fg);
         gen_word_type w;
         logic [39:0]  cols;
         logic [7:0]   col_bits;
         int           g;
         if (restart) begin
            cursor_col = sx;
            cursor_row = sy;
         end
         if (c == gtpg_pkg::CHAR_SPACE) begin
            cursor_col = cursor_col + gtpg_pkg::CURSOR_STEP;
            return;
         end
         g = glyph_of(c);
         if (g < 0) return;

         // Window word first, edges wrapping at 16 bits.
         w      = '0;
         w.kind = gtpg_pkg::KIND_WINDOW;
         w.x0   = cursor_col;
         w.y0   = cursor_row;
         w.x1   = cursor_col + gtpg_pkg::WIN_DX;
         w.y1   = cursor_row + gtpg_pkg::WIN_DY;
         pending_words.push_back(w);

         // Then the cell row by row; the sixth column is always spacing.
         cols = font_columns(g);
         for (int row = 0; row < gtpg_pkg::CELL_ROWS; row++) begin
            for (int col = 0; col < gtpg_pkg::CELL_COLS; col++) begin
               w       = '0;
               w.kind  = gtpg_pkg::KIND_PIXEL;
               w.color = background;
               if (col < gtpg_pkg::FONT_COLS) begin
                  col_bits = cols[8*(gtpg_pkg::FONT_COLS-1-col) +: 8];
                  if (col_bits[row]) w.color = fg;
               end
               w.last = (row == gtpg_pkg::CELL_ROWS-1) && (col == gtpg_pkg::CELL_COLS-1);
               pending_words.push_back(w);
            end
         end
         cursor_col = cursor_col + gtpg_pkg::CURSOR_STEP;
      endfunction

      function string describe(gen_word_type w);
         return $sformatf("kind=%0d x0=%h y0=%h x1=%h y1=%h colour=%h last=%0d",
                          w.kind, w.x0, w.y0, w.x1, w.y1, w.color, w.last);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
      endfunction

      // Compares an accepted word with the oldest one owed.
      function void check_word(gen_word_type got);
         gen_word_type want;
         if (pending_words.size() == 0) begin
            flag({"unexpected word: ", describe(got)});
            return;
         end
         want = pending_words.pop_front();
         if (got !== want) begin
            flag({"word mismatch: expected ", describe(want), ", got ", describe(got)});
         end
      endfunction

      function void check_register(logic [gtpg_pkg::CSR_DATA_W-1:0] got);
         if (got !== gtpg_pkg::CSR_DATA_W'(background)) begin
            flag($sformatf("background register: expected %h, got %h", background, got));
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [gtpg_pkg::CSR_ADDR_W-1:0] paddr;
   logic [gtpg_pkg::CSR_DATA_W-1:0] pwdata;
   logic [gtpg_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;
   logic                            req_valid;
   logic                            req_ready;
   logic [gtpg_pkg::CHAR_W-1:0]     req_char_code;
   logic                            req_restart;
   logic [gtpg_pkg::COORD_W-1:0]    req_start_x;
   logic [gtpg_pkg::COORD_W-1:0]    req_start_y;
   logic [gtpg_pkg::COLOR_W-1:0]    req_fg_color;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_kind;
   logic [gtpg_pkg::COORD_W-1:0]    rsp_win_x0;
   logic [gtpg_pkg::COORD_W-1:0]    rsp_win_y0;
   logic [gtpg_pkg::COORD_W-1:0]    rsp_win_x1;
   logic [gtpg_pkg::COORD_W-1:0]    rsp_win_y1;
   logic [gtpg_pkg::COLOR_W-1:0]    rsp_pixel_color;
   logic                            rsp_last;

   int             tx_idle_pct;
   int             rx_idle_pct;
   logic           hold_off_req;
   logic           hold_taken;
   int             hold_count;
   int             cycle_count = 0;
   glyph_predictor predictor = new();

   glyph_text_pixel_generator u_top (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_restart     (req_restart),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_fg_color    (req_fg_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_win_x0      (rsp_win_x0),
      .rsp_win_y0      (rsp_win_y0),
      .rsp_win_x1      (rsp_win_x1),
      .rsp_win_y1      (rsp_win_y1),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Both handshakes are observed in one place, so a character is always noted
   // before any word it causes is checked.
   always @(posedge clock) begin : observe
      gen_word_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predictor.take_char(req_char_code, req_restart, req_start_x, req_start_y,
                                req_fg_color);
         end
         if (rsp_valid && rsp_ready) begin
            got.kind  = rsp_kind;
            got.x0    = rsp_win_x0;
            got.y0    = rsp_win_y0;
            got.x1    = rsp_win_x1;
            got.y1    = rsp_win_y1;
            got.color = rsp_pixel_color;
            got.last  = rsp_last;
            predictor.check_word(got);
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off when asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_count <= 0;
         hold_taken <= 1'b0;
      end else if (hold_count != 0) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count - 1;
      end else if (hold_off_req && !hold_taken) begin
         rsp_ready  <= 1'b0;
         hold_count <= HOLD_CYCLES - 1;
         hold_taken <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   function automatic logic [gtpg_pkg::CHAR_W-1:0] glyph_char(int g);
      logic [gtpg_pkg::CHAR_W-1:0] c;
      if (g < int'(gtpg_pkg::GLYPH_DIGIT0)) begin
         c = CH_A + gtpg_pkg::CHAR_W'(g);
      end else if (g < int'(gtpg_pkg::GLYPH_PERIOD)) begin
         c = CH_0 + gtpg_pkg::CHAR_W'(g - int'(gtpg_pkg::GLYPH_DIGIT0));
      end else if (g == int'(gtpg_pkg::GLYPH_PERIOD)) begin
         c = CH_PERIOD;
      end else if (g == int'(gtpg_pkg::GLYPH_MINUS)) begin
         c = CH_MINUS;
      end else if (g == int'(gtpg_pkg::GLYPH_COLON)) begin
         c = CH_COLON;
      end else if (g == int'(gtpg_pkg::GLYPH_LPAREN)) begin
         c = CH_LPAREN;
      end else begin
         c = CH_RPAREN;
      end
      return c;
   endfunction

   // Offers one character word and returns at the edge where it is taken.
   task automatic offer_char(input logic [gtpg_pkg::CHAR_W-1:0] c, input logic restart,
                             input logic [gtpg_pkg::COORD_W-1:0] sx,
                             input logic [gtpg_pkg::COORD_W-1:0] sy,
                             input logic [gtpg_pkg::COLOR_W-1:0] fg);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_restart   <= restart;
      req_start_x   <= sx;
      req_start_y   <= sy;
      req_fg_color  <= fg;
      do @(posedge clock); while (!req_ready);
   endtask

   // Mostly drawable text, with spaces, restarts and stray codes mixed in.
   task automatic run_random(input int count);
      logic [gtpg_pkg::CHAR_W-1:0]  c;
      logic                         restart;
      logic [gtpg_pkg::COORD_W-1:0] sx;
      logic [gtpg_pkg::COORD_W-1:0] sy;
      int                           pick;
      int                           taken;
      taken = 0;
      while (taken < count) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            c = glyph_char($urandom_range(gtpg_pkg::GLYPH_COUNT - 1));
         end else if (pick < 80) begin
            c = gtpg_pkg::CHAR_SPACE;
         end else begin
            c = gtpg_pkg::CHAR_W'($urandom_range(255));
         end
         restart = ($urandom_range(99) < 12);
         // Start positions often sit just below the wrap point.
         if ($urandom_range(3) == 0) begin
            sx = 16'hFFFF - gtpg_pkg::COORD_W'($urandom_range(11));
            sy = 16'hFFFF - gtpg_pkg::COORD_W'($urandom_range(11));
         end else begin
            sx = gtpg_pkg::COORD_W'($urandom_range(65535));
            sy = gtpg_pkg::COORD_W'($urandom_range(65535));
         end
         offer_char(c, restart, sx, sy, gtpg_pkg::COLOR_W'($urandom_range(65535)));
         taken++;
      end
   endtask

   // Waits until every owed word has arrived and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predictor.pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [gtpg_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [gtpg_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == ADDR_BACKGROUND) predictor.set_background(data[gtpg_pkg::COLOR_W-1:0]);
   endtask

   // Reads the background register back, sampling in the middle of the access phase.
   task automatic check_background();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_BACKGROUND;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      predictor.check_register(prdata);
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      reset         <= 1'b1;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      req_valid     <= 1'b0;
      req_char_code <= '0;
      req_restart   <= 1'b0;
      req_start_x   <= '0;
      req_start_y   <= '0;
      req_fg_color  <= '0;
      tx_idle_pct   <= 13;
      rx_idle_pct   <= 63;
      hold_off_req  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      check_background();

      // Directed text with the background left at its reset value.
      offer_char(glyph_char(0), 1'b1, 16'h0000, 16'h0000, 16'hFFFF);
      offer_char(CH_Z, 1'b0, 16'h0000, 16'h0000, 16'h0000);
      offer_char(CH_0, 1'b0, 16'h0000, 16'h0000, 16'hA5A5);
      offer_char(CH_9, 1'b0, 16'h0000, 16'h0000, 16'h5A5A);
      offer_char(CH_PERIOD, 1'b0, 16'h0000, 16'h0000, 16'hF800);
      offer_char(CH_MINUS, 1'b0, 16'h0000, 16'h0000, 16'h07E0);
      offer_char(CH_COLON, 1'b0, 16'h0000, 16'h0000, 16'h001F);
      offer_char(CH_LPAREN, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
      offer_char(CH_RPAREN, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
      offer_char(gtpg_pkg::CHAR_SPACE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // Codes with no glyph leave the cursor where it is.
      offer_char(CH_LOWER_A, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
      offer_char(CH_NUL, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
      offer_char(CH_TOP, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      offer_char(glyph_char(1), 1'b0, 16'h0000, 16'h0000, 16'h1234);
      // Window edges and the cursor step wrap past the top of the range.
      offer_char(glyph_char(12), 1'b1, 16'hFFFC, 16'hFFFB, 16'hFFFF);
      offer_char(glyph_char(22), 1'b0, 16'h0000, 16'h0000, 16'h8001);
      offer_char(glyph_char(23), 1'b1, 16'hFFFF, 16'hFFFF, 16'h5555);
      // Restart with a space loads the cursor and then steps it.
      offer_char(gtpg_pkg::CHAR_SPACE, 1'b1, 16'hFFFA, 16'hFFFF, 16'h0000);
      offer_char(glyph_char(1), 1'b0, 16'h0000, 16'h0000, 16'hAAAA);
      // Restart with a stray code only loads the cursor.
      offer_char(CH_AT, 1'b1, 16'h1234, 16'h5678, 16'h0000);
      offer_char(glyph_char(10), 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
      offer_char(CH_HIGH, 1'b1, 16'h8000, 16'h7FFF, 16'h0000);
      offer_char(CH_0 + 8'd8, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
      settle();

      // Sender mostly busy, receiver mostly stalling, white background.
      csr_write(ADDR_BACKGROUND, 32'h0000_FFFF);
      check_background();
      run_random(160);
      settle();

      // Sender mostly idle, receiver mostly ready; an unmapped write must not land.
      tx_idle_pct <= 63;
      rx_idle_pct <= 13;
      csr_write(ADDR_BACKGROUND, gtpg_pkg::CSR_DATA_W'($urandom_range(65535)));
      csr_write(ADDR_UNMAPPED, gtpg_pkg::CSR_DATA_W'($urandom));
      check_background();
      run_random(160);
      settle();

      // Full rate, opening with a long receiver hold-off so the input backs up.
      tx_idle_pct  <= 0;
      rx_idle_pct  <= 0;
      csr_write(ADDR_BACKGROUND, 32'h0000_0000);
      check_background();
      hold_off_req <= 1'b1;
      run_random(130);
      settle();

      if (predictor.mismatches == 0 && predictor.pending_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
